### design/voxel_silhouette_carving_assert.svh
// Assertion macros for the checker file of the voxel carving block.
// Depends on nothing; include by bare file name.
`ifndef VOXEL_SILHOUETTE_CARVING_ASSERT_SVH
`define VOXEL_SILHOUETTE_CARVING_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define VSC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define VSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vsc_pkg.sv
// Package of the voxel silhouette carving block: register codes, shared types.
// Depends on nothing.
`timescale 1ns / 1ps
package vsc_pkg;
    localparam int COEF_W   = 32;
    localparam int SUM_W    = 64;
    localparam int QUOT_W   = 64;
    localparam int MASK_IDX_W = 19;

    localparam logic [2:0] REG_ROW0_AB = 3'd0;
    localparam logic [2:0] REG_ROW0_CD = 3'd1;
    localparam logic [2:0] REG_ROW1_AB = 3'd2;
    localparam logic [2:0] REG_ROW1_CD = 3'd3;
    localparam logic [2:0] REG_ROW2_AB = 3'd4;
    localparam logic [2:0] REG_ROW2_CD = 3'd5;
    localparam logic [2:0] REG_WIDTH   = 3'd6;
    localparam logic [2:0] REG_HEIGHT  = 3'd7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    // A classified request as it crosses the queue from front to back.
    typedef struct packed {
        logic                     mode;
        logic                     coords_ok;
        logic signed [SUM_W-1:0]  sx;
        logic signed [SUM_W-1:0]  sy;
        logic signed [SUM_W-1:0]  sw;
        logic [MASK_IDX_W-1:0]    mask_word_index;
        logic [31:0]              mask_bits;
    } vsc_req_t;

    typedef struct packed {
        logic               keep;
        logic               in_bounds;
        logic signed [15:0] pixel_u;
        logic signed [15:0] pixel_v;
    } vsc_res_t;
endpackage

### design/vsc_front.sv
// Front part: accepts requests and forms the three projection row sums.
// Depends on vsc_pkg.
`timescale 1ns / 1ps
module vsc_front #(
    parameter int GRID_DIM = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [8:0]           in_x,
    input  logic [8:0]           in_y,
    input  logic [8:0]           in_z,
    input  logic [18:0]          in_idx,
    input  logic [31:0]          in_bits,
    input  logic [6*64-1:0]      proj,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vsc_pkg::vsc_req_t    out_req
);
    import vsc_pkg::*;

    // Stage 1: register inputs and products. Stage 2: sum products.
    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg;
    logic        s1_mode_reg, s1_ok_reg;
    logic [18:0] s1_idx_reg;
    logic [31:0] s1_bits_reg;
    logic signed [42:0] prod_reg [0:2][0:2];
    logic signed [31:0] off_reg [0:2];
    vsc_req_t    s2_req_reg;
    logic        adv2, adv1;

    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign s1_valid_next = in_valid;
    assign out_valid = s2_valid_reg;
    assign out_req   = s2_req_reg;

    function automatic logic signed [31:0] coef(input logic [6*64-1:0] p, input int r,
                                                input int k);
        coef = p[r*128 + k*32 +: 32];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= s1_valid_next;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_mode_reg <= in_mode;
            s1_ok_reg   <= (32'(in_x) < GRID_DIM) && (32'(in_y) < GRID_DIM)
                           && (32'(in_z) < GRID_DIM);
            s1_idx_reg  <= in_idx;
            s1_bits_reg <= in_bits;
            for (int r = 0; r < 3; r++) begin
                prod_reg[r][0] <= 43'(coef(proj, r, 0) * $signed({1'b0, in_x}));
                prod_reg[r][1] <= 43'(coef(proj, r, 1) * $signed({1'b0, in_y}));
                prod_reg[r][2] <= 43'(coef(proj, r, 2) * $signed({1'b0, in_z}));
                off_reg[r]     <= coef(proj, r, 3);
            end
        end
        if (adv2) begin
            s2_req_reg.mode            <= s1_mode_reg;
            s2_req_reg.coords_ok       <= s1_ok_reg;
            s2_req_reg.mask_word_index <= s1_idx_reg;
            s2_req_reg.mask_bits       <= s1_bits_reg;
            s2_req_reg.sx <= SUM_W'(prod_reg[0][0]) + SUM_W'(prod_reg[0][1])
                           + SUM_W'(prod_reg[0][2]) + SUM_W'(off_reg[0]);
            s2_req_reg.sy <= SUM_W'(prod_reg[1][0]) + SUM_W'(prod_reg[1][1])
                           + SUM_W'(prod_reg[1][2]) + SUM_W'(off_reg[1]);
            s2_req_reg.sw <= SUM_W'(prod_reg[2][0]) + SUM_W'(prod_reg[2][1])
                           + SUM_W'(prod_reg[2][2]) + SUM_W'(off_reg[2]);
        end
    end
endmodule

### design/vsc_queue.sv
// Short queue of classified requests between the front and back parts.
// Depends on vsc_pkg.
`timescale 1ns / 1ps
module vsc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vsc_pkg::vsc_req_t in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output vsc_pkg::vsc_req_t out_req
);
    import vsc_pkg::*;
    localparam int AW = $clog2(DEPTH);

    vsc_req_t        mem_reg [0:DEPTH-1];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_req   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_req;
    end
endmodule

### design/vsc_divider.sv
// Pipelined signed divider, one quotient bit per stage, a request per cycle while en is high.
// Quotient truncates toward zero. Depends on nothing but its parameters.
`timescale 1ns / 1ps
module vsc_divider #(
    parameter int N  = 64,
    parameter int TW = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [N-1:0] in_num,
    input  logic signed [N-1:0] in_den,
    input  logic [TW-1:0]       in_tag,
    output logic                out_valid,
    output logic signed [N-1:0] out_quot,
    output logic [TW-1:0]       out_tag
);
    // Stage k holds the partial remainder after k quotient bits.
    logic            v_reg   [0:N];
    logic [N-1:0]    rem_reg [0:N];
    logic [N-1:0]    q_reg   [0:N];
    logic [N-1:0]    d_reg   [0:N];
    logic            neg_reg [0:N];
    logic [TW-1:0]   tag_reg [0:N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < N; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            q_reg[0]   <= in_num[N-1] ? N'(-in_num) : N'(in_num);
            d_reg[0]   <= in_den[N-1] ? N'(-in_den) : N'(in_den);
            neg_reg[0] <= in_num[N-1] ^ in_den[N-1];
            tag_reg[0] <= in_tag;
            for (int k = 0; k < N; k++) begin
                logic [N:0] trial;
                trial = {rem_reg[k], q_reg[k][N-1]} - {1'b0, d_reg[k]};
                if (!trial[N]) begin
                    rem_reg[k+1] <= trial[N-1:0];
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= {rem_reg[k][N-2:0], q_reg[k][N-1]};
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b0};
                end
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_quot  = neg_reg[N] ? N'(-q_reg[N]) : q_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

### design/vsc_back.sv
// Back part: divides, bounds-checks, writes and reads the mask, and holds results
// in an output register. Depends on vsc_pkg and vsc_divider.
`timescale 1ns / 1ps
module vsc_back #(
    parameter int MASK_DIM = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vsc_pkg::vsc_req_t in_req,
    input  logic [12:0]       image_width,
    input  logic [12:0]       image_height,
    output logic              out_valid,
    input  logic              out_ready,
    output vsc_pkg::vsc_res_t out_res
);
    import vsc_pkg::*;
    localparam int WPR   = MASK_DIM / 32;
    localparam int DEPTH = MASK_DIM * WPR;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIVL  = SUM_W + 1;
    localparam int TAGW  = 2;
    localparam int WTAGW = 1 + MASK_IDX_W + 32;

    // Pipeline stalls as a whole when the result register is full and not taken.
    logic en;
    logic res_valid_reg;
    vsc_res_t res_reg;

    assign en       = !res_valid_reg || out_ready;
    assign in_ready = en;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    logic               uv_valid, vv_valid;
    logic signed [63:0] u_q, v_q;
    logic [TAGW-1:0]    u_tag;
    logic [WTAGW-1:0]   v_tag;
    logic [TAGW-1:0]    u_in_tag;
    logic [WTAGW-1:0]   v_in_tag;
    assign u_in_tag = {in_req.coords_ok, in_req.sw != '0};
    // Every request passes the dividers so that mask writes stay in order with tests.
    assign v_in_tag = {in_req.mask_bits, in_req.mask_word_index, in_req.mode};

    vsc_divider #(.N(SUM_W), .TW(TAGW)) u_div_u (
        .aclk, .aresetn, .en, .in_valid(in_valid), .in_num(in_req.sx), .in_den(in_req.sw),
        .in_tag(u_in_tag), .out_valid(uv_valid), .out_quot(u_q), .out_tag(u_tag));
    vsc_divider #(.N(SUM_W), .TW(WTAGW)) u_div_v (
        .aclk, .aresetn, .en, .in_valid(in_valid), .in_num(in_req.sy), .in_den(in_req.sw),
        .in_tag(v_in_tag), .out_valid(vv_valid), .out_quot(v_q), .out_tag(v_tag));

    logic                  wr_mode;
    logic [MASK_IDX_W-1:0] wr_idx;
    logic [31:0]           wr_bits;
    assign wr_mode = v_tag[0];
    assign wr_idx  = v_tag[MASK_IDX_W:1];
    assign wr_bits = v_tag[WTAGW-1:MASK_IDX_W+1];

    logic [31:0] mask_mem [0:DEPTH-1];
    always_ff @(posedge aclk) begin
        if (en && vv_valid && wr_mode == MODE_WRITE && 32'(wr_idx) < DEPTH)
            mask_mem[AW'(wr_idx)] <= wr_bits;
    end

    // Classification and mask read stage after the dividers, then the result register.
    logic [13:0] wlim, hlim;
    assign wlim = ({1'b0, image_width}  > 14'(MASK_DIM)) ? 14'(MASK_DIM)
                                                          : {1'b0, image_width};
    assign hlim = ({1'b0, image_height} > 14'(MASK_DIM)) ? 14'(MASK_DIM)
                                                          : {1'b0, image_height};

    logic               c_valid_reg;
    logic               c_inb_reg;
    logic signed [15:0] c_u_reg, c_v_reg;
    logic [4:0]         c_bit_reg;
    logic [31:0]        c_word_reg;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767)       sat16 = 16'sh7fff;
        else if (x < -64'sd32768) sat16 = 16'sh8000;
        else                      sat16 = x[15:0];
    endfunction

    logic nz, inb;
    logic [AW-1:0] widx;
    assign nz  = u_tag[0];
    assign inb = nz && u_tag[1] && !u_q[63] && !v_q[63] &&
                 u_q < 64'(wlim) && v_q < 64'(hlim);
    assign widx = AW'(v_q[12:0]) * AW'(WPR) + AW'(u_q[12:5]);

    always_ff @(posedge aclk) begin
        if (!aresetn) c_valid_reg <= 1'b0;
        else if (en)  c_valid_reg <= uv_valid && vv_valid && wr_mode == MODE_TEST;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_inb_reg  <= inb;
            c_u_reg    <= nz ? sat16(u_q) : '0;
            c_v_reg    <= nz ? sat16(v_q) : '0;
            c_bit_reg  <= u_q[4:0];
            c_word_reg <= mask_mem[widx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) res_valid_reg <= 1'b0;
        else if (en)  res_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.keep      <= c_inb_reg && c_word_reg[c_bit_reg];
            res_reg.in_bounds <= c_inb_reg;
            res_reg.pixel_u   <= c_u_reg;
            res_reg.pixel_v   <= c_v_reg;
        end
    end
endmodule

### design/voxel_silhouette_carving.sv
// Voxel silhouette carving against one camera view.
// Channels: s_axis (tdata packs x, y, z, mask_word_index, mask_bits; tuser is mode),
// m_axis (tdata packs pixel_u, pixel_v; tuser packs keep, in_bounds), and an
// APB-style register port for six 64-bit matrix words and the image size.
// A mode-0 request writes one mask word and gives no result; a mode-1 request
// gives one result.
// Throughput: one request per cycle unless the output stalls. A voxel test is delayed
// mostly by the two pipelined dividers (one quotient bit per stage).
// Mask writes and voxel reads pass the dividers in order through one memory.
// A full output register stalls the back part; the queue between front and back
// then fills, and s_tready falls only when it and the front stages are full.
// Reset clears all valid flags and sets the matrix to zero and the image size to
// 4096 by 4096. The mask store is not cleared; unwritten words read as anything.
`timescale 1ns / 1ps
module voxel_silhouette_carving #(
    parameter int MASK_DIM = 4096,
    parameter int GRID_DIM = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // voxel_x, voxel_y, voxel_z, mask_word_index, mask_bits
    input  logic         s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // pixel_u, pixel_v
    output logic [1:0]   m_tuser,  // keep, in_bounds
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import vsc_pkg::*;

    logic [63:0] proj_reg [0:5];
    logic [12:0] width_reg, height_reg;
    logic [2:0]  ridx;
    logic        wr;
    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) proj_reg[i] <= '0;
            width_reg  <= 13'd4096;
            height_reg <= 13'd4096;
        end else if (wr) begin
            unique case (ridx)
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default:    proj_reg[ridx] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_WIDTH:  prdata = 64'(width_reg);
            REG_HEIGHT: prdata = 64'(height_reg);
            default:    prdata = proj_reg[ridx];
        endcase
    end

    logic [6*64-1:0] proj_flat;
    always_comb begin
        for (int i = 0; i < 6; i++) proj_flat[i*64 +: 64] = proj_reg[i];
    end

    logic     f_valid, f_ready, b_valid, b_ready;
    vsc_req_t f_req, b_req;
    vsc_res_t res;

    vsc_front #(.GRID_DIM(GRID_DIM)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_mode(s_tuser),
        .in_x(s_tdata[8:0]), .in_y(s_tdata[17:9]), .in_z(s_tdata[26:18]),
        .in_idx(s_tdata[45:27]), .in_bits(s_tdata[77:46]), .proj(proj_flat),
        .out_valid(f_valid), .out_ready(f_ready), .out_req(f_req));

    vsc_queue #(.DEPTH(4)) u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
        .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req));

    vsc_back #(.MASK_DIM(MASK_DIM)) u_back (
        .aclk, .aresetn, .in_valid(b_valid), .in_ready(b_ready), .in_req(b_req),
        .image_width(width_reg), .image_height(height_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res));

    assign m_tdata = {res.pixel_v, res.pixel_u};
    assign m_tuser = {res.in_bounds, res.keep};
endmodule

### design/vsc_checker.sv
// Port-level checker for the voxel carving block, bound to the top level.
// Depends on voxel_silhouette_carving_assert.svh.
`timescale 1ns / 1ps
`include "voxel_silhouette_carving_assert.svh"
module vsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);
    `VSC_ASSERT_IMPL(a_keep_in_bounds, aclk, aresetn, m_tvalid && m_tuser[0], m_tuser[1],
        "keep without in_bounds")
    `VSC_ASSERT_IMPL(a_u_nonneg, aclk, aresetn, m_tvalid && m_tuser[1], !m_tdata[15],
        "in-bounds result with negative column")
    `VSC_ASSERT_IMPL(a_v_nonneg, aclk, aresetn, m_tvalid && m_tuser[1], !m_tdata[31],
        "in-bounds result with negative row")
    `VSC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")
    `VSC_ASSERT_IMPL(a_pready, aclk, aresetn, 1'b1, pready, "pready low")
endmodule

bind voxel_silhouette_carving vsc_checker u_vsc_checker (.*);
